// ----- design/gcd_pkg.sv -----
// Shared constants and tables for the great-circle distance pipeline.
// No dependencies; every other file imports this package.
package gcd_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int LAT_W  = 24;
    localparam int LON_W  = 25;
    localparam int DIST_W = 25;
    localparam int COORD_W = 25;

    // degrees to binary turns: t = (mag << TURN_SHIFT + 180) / 360
    localparam int TURN_SHIFT = 32 - ANGLE_FRAC_BITS;
    localparam int W_SHIFT    = TURN_SHIFT - 3;
    localparam int ROUND_W    = 180 / 8;
    localparam logic signed [COORD_W-1:0] LAT_LIMIT = COORD_W'(90 << ANGLE_FRAC_BITS);
    localparam logic [25:0] DIV45_K = 26'd47721859;
    localparam int DIV45_SHIFT = 31;
    localparam int QM_W = 20;
    localparam int W_W  = 27;
    localparam int T2_W = W_SHIFT + 1;

    // CORDIC
    localparam int CORDIC_STEPS = 30;
    localparam int CW = 34;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic signed [CW-1:0] GAIN_INV_Q30 = CW'(652032874);
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // square root over a Q60 radicand
    localparam int SQRT_STEPS = 31;
    localparam int RAD_W = 61;

    localparam logic [23:0] TWO_RADIUS_M = 24'd12742000;
    localparam logic [DIST_W-1:0] HALF_CIRC_M = DIST_W'(20015087);
    localparam logic [DIST_W-1:0] NEAR_LIMIT_RESET = DIST_W'(100000);

    // configuration port
    localparam int PADDR_W = 3;
    localparam logic REG_NEAR_LIMIT = 1'b0;

    // stage counts of each unit
    localparam int TURNS_LAT = 5;
    localparam int ANG_LAT   = 1;
    localparam int COS_LAT   = CORDIC_STEPS + 2;
    localparam int HAV_LAT   = 3;
    localparam int SQRT_LAT  = SQRT_STEPS;
    localparam int ATAN_LAT  = CORDIC_STEPS + 1;
    localparam int PIPE_DEPTH = TURNS_LAT + ANG_LAT + COS_LAT + HAV_LAT + SQRT_LAT + ATAN_LAT;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/gcd_in_if.sv -----
// Input channel: valid/ready handshake carrying two points.
// Depends on gcd_pkg for field widths.
interface gcd_in_if
    import gcd_pkg::*;
();
    logic valid;
    logic ready;
    logic signed [LAT_W-1:0] lat_a;
    logic signed [LON_W-1:0] lon_a;
    logic signed [LAT_W-1:0] lat_b;
    logic signed [LON_W-1:0] lon_b;

    modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
    modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

// ----- design/gcd_out_if.sv -----
// Result channel: valid/ready handshake carrying distance and near flag.
// Depends on gcd_pkg for field widths.
interface gcd_out_if
    import gcd_pkg::*;
();
    logic valid;
    logic ready;
    logic [DIST_W-1:0] distance_m;
    logic is_near;

    modport source (output valid, distance_m, is_near, input ready);
    modport sink   (input valid, distance_m, is_near, output ready);
endinterface

// ----- design/gcd_turns.sv -----
// Signed fixed-point degrees to 32-bit binary turns, rounded half away from zero.
// Five stages; divide by 360 via two reciprocal multiplies. Depends on gcd_pkg.
module gcd_turns
    import gcd_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [COORD_W-1:0] coord,
    output logic [31:0]               turn
);

    logic               neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [COORD_W-1:0] mag1_reg, mag2_reg;
    logic [QM_W-1:0]    qm2_reg, qm3_reg, qm4_reg;
    logic [W_W-1:0]     w3_reg;
    logic [T2_W-1:0]    t2_4_reg;
    logic [31:0]        turn_reg;

    logic [50:0]        prod_a;
    logic [52:0]        prod_b;
    logic [COORD_W-1:0] qm45;
    logic [5:0]         rm;
    logic [W_W-1:0]     w_next;
    logic [31:0]        q;

    // mag = 45*qm + rm, so (mag<<S + 180)/360 = qm<<(S-3) + (rm<<(S-3) + 22)/45
    assign prod_a = 51'(mag1_reg) * 51'(DIV45_K);
    assign qm45   = COORD_W'(qm2_reg) * COORD_W'(45);
    assign rm     = 6'(mag2_reg - qm45);
    assign w_next = (W_W'(rm) << W_SHIFT) + W_W'(ROUND_W);
    assign prod_b = 53'(w3_reg) * 53'(DIV45_K);
    assign q      = (32'(qm4_reg) << W_SHIFT) + 32'(t2_4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= coord[COORD_W-1];
            mag1_reg <= coord[COORD_W-1] ? COORD_W'(-coord) : COORD_W'(coord);
            neg2_reg <= neg1_reg;
            mag2_reg <= mag1_reg;
            qm2_reg  <= prod_a[DIV45_SHIFT +: QM_W];
            neg3_reg <= neg2_reg;
            qm3_reg  <= qm2_reg;
            w3_reg   <= w_next;
            neg4_reg <= neg3_reg;
            qm4_reg  <= qm3_reg;
            t2_4_reg <= prod_b[DIV45_SHIFT +: T2_W];
            turn_reg <= neg4_reg ? (32'd0 - q) : q;
        end
    end

    assign turn = turn_reg;

endmodule

// ----- design/gcd_cos.sv -----
// Cosine of a binary-turn angle in Q30 by a pipelined rotation CORDIC.
// One stage per iteration plus angle scaling and quadrant fold. Depends on gcd_pkg.
module gcd_cos
    import gcd_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        angle,
    output logic signed [31:0] cosv
);

    localparam logic signed [CW-1:0] ONE_C = CW'(ONE_Q30);

    logic signed [CW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] z_reg [0:CORDIC_STEPS];
    logic [1:0]           quad_reg [0:CORDIC_STEPS];
    logic signed [31:0]   cos_reg;

    logic [61:0]          zprod;
    logic signed [CW-1:0] c_sel;
    logic signed [CW-1:0] c_next;

    assign zprod = 62'(angle[29:0]) * 62'(PI_Q30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= GAIN_INV_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= CW'(zprod[61:31]);
            quad_reg[0] <= angle[31:30];
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        localparam logic signed [CW-1:0] ATAN_I = CW'(atan_q30(5'(i)));
        logic signed [CW-1:0] xs, ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ATAN_I;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ATAN_I;
                end
                quad_reg[i+1] <= quad_reg[i];
            end
        end
    end

    // fold the quadrant back in, then clamp to [-1, 1]
    always_comb
    begin
        case (quad_reg[CORDIC_STEPS])
            2'd0:    c_sel = x_reg[CORDIC_STEPS];
            2'd1:    c_sel = -y_reg[CORDIC_STEPS];
            2'd2:    c_sel = -x_reg[CORDIC_STEPS];
            default: c_sel = y_reg[CORDIC_STEPS];
        endcase
        if (c_sel > ONE_C)
            c_next = ONE_C;
        else if (c_sel < -ONE_C)
            c_next = -ONE_C;
        else
            c_next = c_sel;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cos_reg <= c_next[31:0];
    end

    assign cosv = cos_reg;

endmodule

// ----- design/gcd_isqrt.sv -----
// Integer square root of a 61-bit radicand, one result bit per stage.
// Restoring digit-by-digit method. Depends on gcd_pkg.
module gcd_isqrt
    import gcd_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [RAD_W-1:0] radicand,
    output logic [30:0]      root
);

    logic [RAD_W-1:0] v_reg [0:SQRT_STEPS-1];
    logic [RAD_W:0]   r_reg [0:SQRT_STEPS-1];

    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_step
        localparam logic [RAD_W:0] BIT_S = (RAD_W+1)'(1) << (RAD_W - 1 - 2 * s);
        logic [RAD_W-1:0] v_cur;
        logic [RAD_W:0]   r_cur;
        logic [RAD_W:0]   sum;

        if (s == 0)
        begin : g_first
            assign v_cur = radicand;
            assign r_cur = '0;
        end
        else
        begin : g_next
            assign v_cur = v_reg[s-1];
            assign r_cur = r_reg[s-1];
        end

        assign sum = r_cur + BIT_S;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ({1'b0, v_cur} >= sum)
                begin
                    v_reg[s] <= v_cur - sum[RAD_W-1:0];
                    r_reg[s] <= (r_cur >> 1) + BIT_S;
                end
                else
                begin
                    v_reg[s] <= v_cur;
                    r_reg[s] <= r_cur >> 1;
                end
            end
        end
    end

    assign root = r_reg[SQRT_STEPS-1][30:0];

endmodule

// ----- design/gcd_atan.sv -----
// Central angle by a pipelined vectoring CORDIC on (sqrt(1-a), sqrt(a)),
// then scaled to rounded metres. Depends on gcd_pkg.
module gcd_atan
    import gcd_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [30:0]       x_in,
    input  logic [30:0]       y_in,
    output logic [DIST_W-1:0] dist_raw
);

    logic signed [CW-1:0] x_reg [0:CORDIC_STEPS-1];
    logic signed [CW-1:0] y_reg [0:CORDIC_STEPS-1];
    logic signed [CW-1:0] z_reg [0:CORDIC_STEPS-1];
    logic [54:0]          d_reg;

    logic signed [CW-1:0] z_fin;
    logic [30:0]          z_pos;
    logic [54:0]          d_next;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        localparam logic signed [CW-1:0] ATAN_I = CW'(atan_q30(5'(i)));
        logic signed [CW-1:0] x_cur, y_cur, z_cur, xs, ys;

        if (i == 0)
        begin : g_first
            assign x_cur = CW'(x_in);
            assign y_cur = CW'(y_in);
            assign z_cur = '0;
        end
        else
        begin : g_next
            assign x_cur = x_reg[i-1];
            assign y_cur = y_reg[i-1];
            assign z_cur = z_reg[i-1];
        end

        assign xs = x_cur >>> i;
        assign ys = y_cur >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_cur > 0)
                begin
                    x_reg[i] <= x_cur + ys;
                    y_reg[i] <= y_cur - xs;
                    z_reg[i] <= z_cur + ATAN_I;
                end
                else
                begin
                    x_reg[i] <= x_cur - ys;
                    y_reg[i] <= y_cur + xs;
                    z_reg[i] <= z_cur - ATAN_I;
                end
            end
        end
    end

    // drop a negative angle, then d = 2R * c_half with rounding
    assign z_fin  = z_reg[CORDIC_STEPS-1];
    assign z_pos  = z_fin[CW-1] ? 31'd0 : z_fin[30:0];
    assign d_next = 55'(z_pos) * 55'(TWO_RADIUS_M) + (55'(1) << 29);

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign dist_raw = d_reg[30 +: DIST_W];

endmodule

// ----- design/great_circle_distance.sv -----
// Haversine great-circle distance, fully pipelined: one point pair per cycle
// unless a stalled result holds the pipeline. Depth is set mainly by the
// 30-stage cosine and arctangent CORDIC units and the 31-stage square root.
// A stalled result stops the pipeline only once the stage feeding it is full.
// rst_n clears valid bits, output valid and sets the near limit to 100000 m.
// Depends on gcd_pkg, gcd_in_if, gcd_out_if, gcd_turns, gcd_cos, gcd_isqrt, gcd_atan.
module great_circle_distance
    import gcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    gcd_in_if.sink             points,
    gcd_out_if.source          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [DIST_W-1:0]     limit_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  out_valid_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic                  near_reg;

    logic                  en;
    logic                  accept;
    logic                  vld_last;

    logic signed [COORD_W-1:0] la_ext, lb_ext, la_cl, lb_cl;
    logic [31:0]           ta, tb, toa, tob;
    logic [31:0]           ang_reg [0:3];
    logic signed [31:0]    cval [0:3];

    logic signed [63:0]    cc_prod_reg;
    logic [30:0]           hav_lat_reg, hav_lon_reg, hav_lat2_reg;
    logic [47:0]           pp_hi_reg, pp_lo_reg;
    logic [30:0]           a_reg;

    logic signed [32:0]    hav_lat_diff, hav_lon_diff;
    logic [33:0]           cc;
    logic [63:0]           prod_full;
    logic [34:0]           a_sum;
    logic [30:0]           a_next;
    logic [30:0]           sq_y, sq_x;
    logic [DIST_W-1:0]     dist_raw, dist_sat;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NEAR_LIMIT) ? 32'(limit_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= NEAR_LIMIT_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_NEAR_LIMIT)
            limit_reg <= pwdata[DIST_W-1:0];
    end

    // pipeline advance: blocked only when the last stage and the output are both full
    assign vld_last     = vld_reg[PIPE_DEPTH-1];
    assign en           = !vld_last || !out_valid_reg || result.ready;
    assign points.ready = en;
    assign accept       = points.valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], accept};
    end

    // saturate latitudes to +-90 degrees
    assign la_ext = COORD_W'(points.lat_a);
    assign lb_ext = COORD_W'(points.lat_b);
    assign la_cl  = (la_ext > LAT_LIMIT) ? LAT_LIMIT :
                    (la_ext < -LAT_LIMIT) ? -LAT_LIMIT : la_ext;
    assign lb_cl  = (lb_ext > LAT_LIMIT) ? LAT_LIMIT :
                    (lb_ext < -LAT_LIMIT) ? -LAT_LIMIT : lb_ext;

    gcd_turns u_turns_la (.clk(clk), .en(en), .coord(la_cl), .turn(ta));
    gcd_turns u_turns_lb (.clk(clk), .en(en), .coord(lb_cl), .turn(tb));
    gcd_turns u_turns_oa (.clk(clk), .en(en), .coord(points.lon_a), .turn(toa));
    gcd_turns u_turns_ob (.clk(clk), .en(en), .coord(points.lon_b), .turn(tob));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg[0] <= ta;
            ang_reg[1] <= tb;
            ang_reg[2] <= tb - ta;
            ang_reg[3] <= tob - toa;
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_cos
        gcd_cos u_cos (.clk(clk), .en(en), .angle(ang_reg[k]), .cosv(cval[k]));
    end

    // haversine term a, products wrap as in 64-bit unsigned arithmetic
    assign hav_lat_diff = 33'(ONE_Q30) - 33'(cval[2]);
    assign hav_lon_diff = 33'(ONE_Q30) - 33'(cval[3]);
    assign cc           = cc_prod_reg[63:30];
    assign prod_full    = 64'({pp_hi_reg, 17'b0}) + 64'(pp_lo_reg);
    assign a_sum        = 35'(hav_lat2_reg) + 35'(prod_full[63:30]);
    assign a_next       = (a_sum > 35'(ONE_Q30)) ? ONE_Q30 : a_sum[30:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_prod_reg  <= 64'(cval[0]) * 64'(cval[1]);
            hav_lat_reg  <= hav_lat_diff[31:1];
            hav_lon_reg  <= hav_lon_diff[31:1];
            pp_hi_reg    <= 48'(cc[33:17]) * 48'(hav_lon_reg);
            pp_lo_reg    <= 48'(cc[16:0]) * 48'(hav_lon_reg);
            hav_lat2_reg <= hav_lat_reg;
            a_reg        <= a_next;
        end
    end

    gcd_isqrt u_sqrt_a (
        .clk(clk), .en(en), .radicand({a_reg, 30'b0}), .root(sq_y)
    );
    gcd_isqrt u_sqrt_b (
        .clk(clk), .en(en), .radicand({ONE_Q30 - a_reg, 30'b0}), .root(sq_x)
    );

    gcd_atan u_atan (
        .clk(clk), .en(en), .x_in(sq_x), .y_in(sq_y), .dist_raw(dist_raw)
    );

    assign dist_sat = (dist_raw > HALF_CIRC_M) ? HALF_CIRC_M : dist_raw;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en && vld_last)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_last)
        begin
            dist_reg <= dist_sat;
            near_reg <= dist_sat < limit_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.distance_m = dist_reg;
    assign result.is_near    = near_reg;

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.distance_m <= HALF_CIRC_M)
        else $error("distance beyond half circumference");

    a_near_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.is_near == (result.distance_m < limit_reg))
        else $error("near flag disagrees with limit");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !points.ready |-> (result.valid && !result.ready))
        else $error("input stalled without a blocked result");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(vld_last))
        else $error("result appeared without a pipeline item");

endmodule
